// ===== sv/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// shared constants, types and helpers for the touch calibrate and report block
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

    localparam int KEY_W    = 16;
    localparam int RAW_W    = 12;
    localparam int PIX_W    = 8;
    localparam int IDX_W    = 2;

    // calibration scale factors and offset
    localparam int X_SCALE  = 256 - 62;
    localparam int Y_SCALE  = 192 - 62;
    localparam int SCALE_W  = 8;
    localparam int OFFSET   = 31;
    localparam int X_MAX    = 255;
    localparam int Y_MAX    = 191;
    localparam int PEN_UP_BIT = 6;

    // |diff| * scale fits in 20 bits, so does the quotient
    localparam int PROD_W   = RAW_W + SCALE_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = PROD_W / STEPS_PER_STAGE;
    localparam int TAG_DEPTH  = DIV_STAGES + 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CAL_X_LOW = 2'd0;
    localparam logic [IDX_W-1:0] REG_CAL_Y_LOW = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPAN_X    = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPAN_Y    = 2'd3;

    // message kinds
    localparam logic KIND_BUTTONS = 1'b0;
    localparam logic KIND_TOUCH   = 1'b1;

    typedef struct packed {
        logic [RAW_W-1:0] cal_x_low;
        logic [RAW_W-1:0] cal_y_low;
        logic [RAW_W-1:0] div_x;
        logic [RAW_W-1:0] div_y;
    } cal_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] keys;
        logic             pen_down;
        logic             neg_x;
        logic             neg_y;
    } tag_t;

    // signed quotient plus offset, clamped to 0..hi
    function automatic logic [PIX_W-1:0] clamp_pix(
        input logic [PROD_W-1:0] q,
        input logic              neg,
        input logic [PIX_W-1:0]  hi
    );
        logic [PROD_W-1:0] lim;
        logic [PIX_W-1:0]  res;
        lim = PROD_W'(hi) - PROD_W'(OFFSET);
        if (neg) begin
            if (q > PROD_W'(OFFSET))
                res = '0;
            else
                res = PIX_W'(OFFSET) - q[PIX_W-1:0];
        end
        else begin
            if (q > lim)
                res = hi;
            else
                res = q[PIX_W-1:0] + PIX_W'(OFFSET);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tcr_cfg_regs
// calibration register file; zero spans read back as one for the dividers
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_cfg_regs
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tcr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tcr_pkg::RAW_W-1:0] cfg_data,
    output tcr_pkg::cal_t                  cal
);
    import tcr_pkg::*;

    logic [RAW_W-1:0] cal_x_low_reg;
    logic [RAW_W-1:0] cal_y_low_reg;
    logic [RAW_W-1:0] span_x_reg;
    logic [RAW_W-1:0] span_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_x_low_reg <= '0;
            cal_y_low_reg <= '0;
            span_x_reg    <= '1;
            span_y_reg    <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_X_LOW: cal_x_low_reg <= cfg_data;
                REG_CAL_Y_LOW: cal_y_low_reg <= cfg_data;
                REG_SPAN_X:    span_x_reg    <= cfg_data;
                REG_SPAN_Y:    span_y_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cal.cal_x_low = cal_x_low_reg;
    assign cal.cal_y_low = cal_y_low_reg;
    assign cal.div_x     = (span_x_reg == '0) ? RAW_W'(1) : span_x_reg;
    assign cal.div_y     = (span_y_reg == '0) ? RAW_W'(1) : span_y_reg;

endmodule

`default_nettype wire

// ===== sv/tcr_div_lane.sv =====
// ----------------------------------------------------------------------------
// tcr_div_lane
// pipelined restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_div_lane
(
    input  wire logic                       clk,
    input  wire logic [tcr_pkg::PROD_W-1:0] dividend,
    input  wire logic [tcr_pkg::RAW_W-1:0]  divisor,
    output logic      [tcr_pkg::PROD_W-1:0] quotient
);
    import tcr_pkg::*;

    // work holds the unused dividend bits on top and the quotient bits below
    logic [RAW_W-1:0]  rem_reg  [DIV_STAGES];
    logic [PROD_W-1:0] work_reg [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            logic [RAW_W-1:0]  rem_in;
            logic [PROD_W-1:0] work_in;
            logic [RAW_W-1:0]  rem_next;
            logic [PROD_W-1:0] work_next;

            if (g == 0)
            begin : g_first
                assign rem_in  = '0;
                assign work_in = dividend;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign work_in = work_reg[g-1];
            end

            always_comb
            begin
                logic [RAW_W:0] trial;
                rem_next  = rem_in;
                work_next = work_in;
                for (int s = 0; s < STEPS_PER_STAGE; s++)
                begin
                    trial     = {rem_next, work_next[PROD_W-1]};
                    work_next = {work_next[PROD_W-2:0], 1'b0};
                    if (trial >= {1'b0, divisor})
                    begin
                        trial        = trial - {1'b0, divisor};
                        work_next[0] = 1'b1;
                    end
                    rem_next = trial[RAW_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                work_reg[g] <= work_next;
            end
        end
    endgenerate

    assign quotient = work_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/touch_calibrate_and_report.sv =====
// ----------------------------------------------------------------------------
// touch_calibrate_and_report
// turns each frame tick into a buttons item and a calibrated touch item
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  input     | start / busy         | keys, raw_x, raw_y
//  result    | strobe (no back-off) | kind, key_word, pen_down, screen_x,
//            |                      | screen_y, last
//  config    | cfg_we               | cfg_index, cfg_data
//
//  - busy is high for the cycle after an accept, so the next input item waits:
//    each item makes two result items and the result port moves one per cycle
//  - path of the buttons item: front stage, constant multiply, 10 divider
//    stages, output register; the touch item follows on the next cycle
//  - rst_n clears all valid bits, busy and the calibration registers
//    (offsets 0, spans 4095); no clearing pass
//  - the receiver cannot stall, so the pipeline advances every cycle
//
`default_nettype none

module touch_calibrate_and_report
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input items
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [tcr_pkg::KEY_W-1:0] keys,
    input  wire logic [tcr_pkg::RAW_W-1:0] raw_x,
    input  wire logic [tcr_pkg::RAW_W-1:0] raw_y,
    // result items
    output logic                           strobe,
    output logic                           kind,
    output logic      [tcr_pkg::KEY_W-1:0] key_word,
    output logic                           pen_down,
    output logic      [tcr_pkg::PIX_W-1:0] screen_x,
    output logic      [tcr_pkg::PIX_W-1:0] screen_y,
    output logic                           last,
    // configuration
    input  wire logic                      cfg_we,
    input  wire logic [tcr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tcr_pkg::RAW_W-1:0] cfg_data
);
    import tcr_pkg::*;

    cal_t cal;

    tcr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // ---------------- accept and throttle ----------------
    logic accept;
    logic busy_reg;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // ---------------- front stage: signed differences ----------------
    logic [RAW_W:0]   dx;
    logic [RAW_W:0]   dy;
    tag_t             s0_tag_reg;
    tag_t             s0_tag_next;
    logic [RAW_W-1:0] mag_x_reg;
    logic [RAW_W-1:0] mag_y_reg;

    assign dx = {1'b0, raw_x} - {1'b0, cal.cal_x_low};
    assign dy = {1'b0, raw_y} - {1'b0, cal.cal_y_low};

    always_comb
    begin
        s0_tag_next.valid    = accept;
        s0_tag_next.keys     = keys;
        s0_tag_next.pen_down = !keys[PEN_UP_BIT];
        s0_tag_next.neg_x    = dx[RAW_W];
        s0_tag_next.neg_y    = dy[RAW_W];
    end

    always_ff @(posedge clk)
    begin
        // magnitude of a 13-bit difference never exceeds 4095
        mag_x_reg <= dx[RAW_W] ? RAW_W'(-dx) : dx[RAW_W-1:0];
        mag_y_reg <= dy[RAW_W] ? RAW_W'(-dy) : dy[RAW_W-1:0];
    end

    // ---------------- multiply stage ----------------
    logic [PROD_W-1:0] prod_x_reg;
    logic [PROD_W-1:0] prod_y_reg;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= PROD_W'(mag_x_reg) * PROD_W'(X_SCALE);
        prod_y_reg <= PROD_W'(mag_y_reg) * PROD_W'(Y_SCALE);
    end

    // ---------------- divider lanes ----------------
    logic [PROD_W-1:0] quot_x;
    logic [PROD_W-1:0] quot_y;

    tcr_div_lane u_div_x
    (
        .clk      (clk),
        .dividend (prod_x_reg),
        .divisor  (cal.div_x),
        .quotient (quot_x)
    );

    tcr_div_lane u_div_y
    (
        .clk      (clk),
        .dividend (prod_y_reg),
        .divisor  (cal.div_y),
        .quotient (quot_y)
    );

    // ---------------- tag line, aligned with the divider output ----------------
    // tag_reg[0] sits beside the products, the last entry beside the quotients
    tag_t tag_reg [TAG_DEPTH];
    tag_t tag_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            s0_tag_reg <= '0;
            for (int i = 0; i < TAG_DEPTH; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            busy_reg   <= accept;
            s0_tag_reg <= s0_tag_next;
            tag_reg[0] <= s0_tag_reg;
            for (int i = 1; i < TAG_DEPTH; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign tag_out = tag_reg[TAG_DEPTH-1];

    // ---------------- clamp and output register ----------------
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;

    assign pix_x = tag_out.pen_down ? clamp_pix(quot_x, tag_out.neg_x, PIX_W'(X_MAX)) : '0;
    assign pix_y = tag_out.pen_down ? clamp_pix(quot_y, tag_out.neg_y, PIX_W'(Y_MAX)) : '0;

    // touch item is held in the pend registers and goes out in the cycle after its buttons item
    logic             pend_valid_reg;
    logic             pend_pen_reg;
    logic [PIX_W-1:0] pend_x_reg;
    logic [PIX_W-1:0] pend_y_reg;

    logic             strobe_reg;
    logic             kind_reg;
    logic [KEY_W-1:0] key_word_reg;
    logic             pen_down_reg;
    logic [PIX_W-1:0] screen_x_reg;
    logic [PIX_W-1:0] screen_y_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= tag_out.valid;
            strobe_reg     <= tag_out.valid || pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pen_reg <= tag_out.pen_down;
        pend_x_reg   <= pix_x;
        pend_y_reg   <= pix_y;
        if (tag_out.valid)
        begin
            kind_reg     <= KIND_BUTTONS;
            key_word_reg <= tag_out.keys;
            pen_down_reg <= 1'b0;
            screen_x_reg <= '0;
            screen_y_reg <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            kind_reg     <= KIND_TOUCH;
            key_word_reg <= '0;
            pen_down_reg <= pend_pen_reg;
            screen_x_reg <= pend_x_reg;
            screen_y_reg <= pend_y_reg;
            last_reg     <= 1'b1;
        end
    end

    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign key_word = key_word_reg;
    assign pen_down = pen_down_reg;
    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;
    assign last     = last_reg;

    // ---------------- checks ----------------
    a_touch_follows_buttons: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_BUTTONS |=> strobe && kind == KIND_TOUCH)
        else $error("buttons item not followed by touch item");

    a_touch_after_buttons: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_TOUCH |-> $past(strobe && kind == KIND_BUTTONS))
        else $error("touch item without preceding buttons item");

    a_pen_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_TOUCH && !pen_down |-> screen_x == '0 && screen_y == '0)
        else $error("pen up touch item carries coordinates");

    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> screen_y <= PIX_W'(Y_MAX))
        else $error("screen_y beyond clamp");

    a_no_tag_collision: assert property (@(posedge clk) disable iff (!rst_n)
        tag_out.valid |-> !pend_valid_reg)
        else $error("two items reach the output back to back");

endmodule

`default_nettype wire

// ===== tb/touch_calibrate_and_report_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_calibrate_and_report_test
// drives frame ticks through the calibrate and report block under a range of
// calibration settings and checks every buttons and touch item it reports
// ----------------------------------------------------------------------------

module touch_calibrate_and_report_test;

    import tcr_pkg::*;

    // one reported item, as seen on the result ports
    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key_word;
        logic             pen_down;
        logic [PIX_W-1:0] screen_x;
        logic [PIX_W-1:0] screen_y;
        logic             last;
    } touch_msg_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the item pair of each accepted tick and checks
    // the reported items against it in order
    // ------------------------------------------------------------------------
    class touch_msg_board;
        touch_msg_t       expected_msgs[$];
        logic [RAW_W-1:0] cal_x_low;
        logic [RAW_W-1:0] cal_y_low;
        logic [RAW_W-1:0] span_x;
        logic [RAW_W-1:0] span_y;
        int               mismatches;
        int               msgs_checked;
        int               ticks;
        int               pen_down_ticks;

        function new();
            cal_x_low      = '0;
            cal_y_low      = '0;
            span_x         = 12'd4095;
            span_y         = 12'd4095;
            mismatches     = 0;
            msgs_checked   = 0;
            ticks          = 0;
            pen_down_ticks = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] val);
            case (idx)
                REG_CAL_X_LOW: cal_x_low = val;
                REG_CAL_Y_LOW: cal_y_low = val;
                REG_SPAN_X:    span_x    = val;
                REG_SPAN_Y:    span_y    = val;
                default: ;
            endcase
        endfunction

        // linear map of one axis; zero span counts as one, division
        // truncates toward zero, then clamp to 0..hi
        function logic [PIX_W-1:0] calibrate_axis(logic [RAW_W-1:0] raw,
                                                  logic [RAW_W-1:0] low,
                                                  logic [RAW_W-1:0] span,
                                                  int scale, int hi);
            int d;
            int s;
            int v;
            d = int'(raw) - int'(low);
            s = (span == '0) ? 1 : int'(span);
            v = (d * scale) / s + OFFSET;
            if (v < 0)
                v = 0;
            if (v > hi)
                v = hi;
            return v[PIX_W-1:0];
        endfunction

        function void note_tick(logic [KEY_W-1:0] k, logic [RAW_W-1:0] x,
                                logic [RAW_W-1:0] y);
            touch_msg_t buttons;
            touch_msg_t touch;
            logic       down;
            down = (k[PEN_UP_BIT] == 1'b0);
            buttons = '0;
            buttons.kind     = KIND_BUTTONS;
            buttons.key_word = k;
            touch = '0;
            touch.kind     = KIND_TOUCH;
            touch.pen_down = down;
            touch.last     = 1'b1;
            if (down)
            begin
                touch.screen_x = calibrate_axis(x, cal_x_low, span_x, X_SCALE, X_MAX);
                touch.screen_y = calibrate_axis(y, cal_y_low, span_y, Y_SCALE, Y_MAX);
                pen_down_ticks++;
            end
            expected_msgs.push_back(buttons);
            expected_msgs.push_back(touch);
            ticks++;
        endfunction

        function void check_msg(touch_msg_t got);
            touch_msg_t want;
            if (expected_msgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: item reported with nothing expected: kind %0d key %h",
                             $realtime, got.kind, got.key_word);
                return;
            end
            want = expected_msgs.pop_front();
            msgs_checked++;
            if (got.kind !== want.kind || got.key_word !== want.key_word
                || got.pen_down !== want.pen_down || got.screen_x !== want.screen_x
                || got.screen_y !== want.screen_y || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: item mismatch", $realtime);
                    $display("  expected kind %0d key %h pen %0d x %0d y %0d last %0d",
                             want.kind, want.key_word, want.pen_down,
                             want.screen_x, want.screen_y, want.last);
                    $display("  actual   kind %0d key %h pen %0d x %0d y %0d last %0d",
                             got.kind, got.key_word, got.pen_down,
                             got.screen_x, got.screen_y, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [KEY_W-1:0] keys = '0;
    logic [RAW_W-1:0] raw_x = '0;
    logic [RAW_W-1:0] raw_y = '0;
    logic             strobe;
    logic             kind;
    logic [KEY_W-1:0] key_word;
    logic             pen_down;
    logic [PIX_W-1:0] screen_x;
    logic [PIX_W-1:0] screen_y;
    logic             last;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [RAW_W-1:0] cfg_data = '0;

    touch_msg_board board;
    int             settings_used;

    touch_calibrate_and_report dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .keys      (keys),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .strobe    (strobe),
        .kind      (kind),
        .key_word  (key_word),
        .pen_down  (pen_down),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // port monitor: all values are sampled at the rising edge, before any
    // update that the edge itself causes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        touch_msg_t seen;
        if (rst_n)
        begin
            // tick accepted: predict its two items with the current settings
            if (start && !busy)
                board.note_tick(keys, raw_x, raw_y);
            if (strobe)
            begin
                seen.kind     = kind;
                seen.key_word = key_word;
                seen.pen_down = pen_down;
                seen.screen_x = screen_x;
                seen.screen_y = screen_y;
                seen.last     = last;
                board.check_msg(seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one register write; the enable stays up so writes can run back to back
    task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.set_reg(idx, val);
    endtask

    // full calibration setting, only called while nothing is in flight
    task automatic set_calibration(input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] yl,
                                   input logic [RAW_W-1:0] sx, input logic [RAW_W-1:0] sy);
        write_cal(REG_CAL_X_LOW, xl);
        write_cal(REG_CAL_Y_LOW, yl);
        write_cal(REG_SPAN_X, sx);
        write_cal(REG_SPAN_Y, sy);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // present one tick, with random idle cycles ahead of it; returns at the
    // edge where it was taken, leaving start high
    task automatic send_tick(input logic [KEY_W-1:0] k, input logic [RAW_W-1:0] x,
                             input logic [RAW_W-1:0] y, input int idle_pct);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        keys  <= k;
        raw_x <= x;
        raw_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // drop start and wait until both items of every tick have come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic logic [RAW_W-1:0] pick_low();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 12'd4095;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_span();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 12'd1;
            2: return 12'd4095;
            3: return RAW_W'($urandom_range(1, 16));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // raw reading: extremes, near the calibration point (sign change of the
    // difference), or anywhere
    function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] low);
        int r;
        case ($urandom_range(0, 5))
            0: r = 0;
            1: r = 4095;
            2: r = int'(low) + $urandom_range(0, 8) - 4;
            default: r = $urandom_range(0, 4095);
        endcase
        if (r < 0)
            r = 0;
        if (r > 4095)
            r = 4095;
        return r[RAW_W-1:0];
    endfunction

    // key word, mostly with the pen down so the calibration path is busy
    function automatic logic [KEY_W-1:0] pick_keys();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        k[PEN_UP_BIT] = ($urandom_range(0, 3) == 0);
        return k;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int idle_pct;
        int n;
        board = new();
        settings_used = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: offsets 0, spans 4095
        send_tick(16'h0000, 12'd0, 12'd0, 0);
        send_tick(16'h0000, 12'd4095, 12'd4095, 0);
        send_tick(16'hFFFF, 12'd4095, 12'd4095, 0);       // pen up, all keys
        send_tick(16'h0040, 12'd1234, 12'd2345, 0);       // pen up bit alone
        send_tick(16'hFFBF, 12'd2048, 12'd1024, 0);       // pen down, other keys all set
        send_tick(16'hA5A5, 12'd1, 12'd4094, 0);
        settle();

        // high offsets with zero and unit spans: negatives clamp low,
        // positives clamp at the top
        set_calibration(12'd4095, 12'd2048, 12'd0, 12'd1);
        send_tick(16'h0000, 12'd0, 12'd0, 0);
        send_tick(16'h0000, 12'd4094, 12'd2047, 0);
        send_tick(16'h0000, 12'd4095, 12'd2048, 0);
        send_tick(16'h0000, 12'd4095, 12'd2049, 0);
        send_tick(16'h5A1B, 12'd4095, 12'd4095, 0);
        settle();

        // spans chosen so a one-count difference gives exactly plus or minus one half:
        // truncation toward zero lands on the offset itself
        set_calibration(12'd100, 12'd100, 12'd388, 12'd260);
        send_tick(16'h0000, 12'd99, 12'd99, 0);
        send_tick(16'h0000, 12'd101, 12'd101, 0);
        send_tick(16'h0000, 12'd0, 12'd0, 0);
        send_tick(16'h0000, 12'd4095, 12'd4095, 0);
        settle();

        // random phases: sender idles often, then more often, then never
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_pct = (ph < 4) ? 27 : (ph < 8) ? 53 : 0;
            set_calibration(pick_low(), pick_low(), pick_span(), pick_span());
            n = 42;
            for (int i = 0; i < n; i++)
                send_tick(pick_keys(), pick_raw(board.cal_x_low),
                          pick_raw(board.cal_y_low), idle_pct);
            settle();
        end

        // drain margin beyond the pipeline depth
        repeat (20) @(posedge clk);

        if (board.pending() > 0)
        begin
            $display("%0d expected items never reported", board.pending());
            board.mismatches += board.pending();
        end

        $display("covered %0d ticks (%0d pen down) over %0d calibration settings",
                 board.ticks, board.pen_down_ticks, settings_used);
        $display("checked %0d reported items, %0d errors",
                 board.msgs_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("touch_calibrate_and_report verification clean");
        else
            $display("touch_calibrate_and_report verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("timeout waiting for the block");
        $display("touch_calibrate_and_report verification failed");
        $finish;
    end

endmodule
